// File: rtl/rkcf_pkg.sv
package rkcf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int COEF_BITS_DEF  = 8;

  localparam int PIX_W   = 32;
  localparam int ACC_W   = 22;
  localparam int SCALE_W = 18;
  localparam int OFFS_W  = 10;
  localparam int PROD_W  = ACC_W + SCALE_W;
  localparam int COEF_VEC_W = 200;
  localparam int ROW_MAX = 4095;

  // Configuration register indexes.
  localparam logic [2:0] REG_KERNEL = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_COEF0  = 3'd2;
  localparam logic [2:0] REG_COEF1  = 3'd3;
  localparam logic [2:0] REG_COEF2  = 3'd4;
  localparam logic [2:0] REG_COEF3  = 3'd5;
  localparam logic [2:0] REG_SCALE  = 3'd6;
  localparam logic [2:0] REG_OFFSET = 3'd7;

  // Datapath controls from the sequencer.
  typedef struct packed {
    logic shift;
    logic clear;
    logic mac_en;
    logic scale_en;
  } ctl_t;

endpackage

// File: rtl/rgb_kernel_convolution_filter.sv
// Streaming 3x3/5x5 convolution on ARGB pixels in raster order. Each accepted
// pixel is registered on entry and then goes through the line store read-
// modify-write; when it completes a window, the taps are multiply-accumulated
// (all three colors at once), the sums are scaled and the result register is
// loaded. A border pixel ends after the line store update. A new pixel is
// accepted only once the previous one has left the sequencer, but the next
// pixel is taken while a result still waits in the output register. The line
// store is a single-port-per-side memory with one word per column holding
// the rows above; it is not cleared after reset, and the first rows of a
// frame simply produce no output.
module rgb_kernel_convolution_filter #(
  parameter int MAX_WIDTH  = rkcf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = rkcf_pkg::MAX_KERNEL_DEF,
  parameter int COEF_BITS  = rkcf_pkg::COEF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // alpha [7:0], red [15:8], green [23:16], blue [31:24]
  input  logic [31:0] in_tdata,
  // last_in_frame
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // alpha [7:0], red [15:8], green [23:16], blue [31:24], column [42:32],
  // row [54:43], zero [55]
  output logic [55:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (MAX_KERNEL-1)*rkcf_pkg::PIX_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_MAC   = 5'b00100,
    S_SCALE = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] col_r;
  logic [11:0]   row_r;
  logic [31:0]   pix_r;
  logic          last_r;
  logic [10:0]   ocol_r;
  logic [11:0]   orow_r;
  logic          out_tvalid_r;
  logic [55:0]   out_tdata_r;

  logic [2:0]  ks_r;
  logic [11:0] width_r;
  logic [63:0] coef0_r, coef1_r, coef2_r;
  logic [7:0]  coef3_r;
  logic signed [17:0] scale_r;
  logic signed [9:0]  offset_r;

  logic accept, k5, emit, mac_last;
  logic [13:0] weff, cnext;
  logic [2:0]  km1, half;
  logic [LW-1:0] above;
  logic [31:0] pix_in;
  logic [7:0]  r_a, r_r, r_g, r_b;
  rkcf_pkg::ctl_t ctl;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The stored word keeps alpha in the top byte and blue in the bottom one.
  assign pix_in = {pix_r[7:0], pix_r[15:8], pix_r[23:16], pix_r[31:24]};

  always_comb begin
    k5   = (ks_r >= 3'd5) && (MAX_KERNEL >= 5);
    km1  = k5 ? 3'd4 : 3'd2;
    half = k5 ? 3'd2 : 3'd1;
    if (width_r == 12'd0) begin
      weff = 14'd1;
    end else if (14'(width_r) > 14'(MAX_WIDTH)) begin
      weff = 14'(MAX_WIDTH);
    end else begin
      weff = 14'(width_r);
    end
    cnext = 14'(col_r) + 14'd1;
    emit  = (14'(col_r) >= 14'(km1)) && (row_r >= 12'(km1));
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r     <= 3'd3;
      width_r  <= 12'd640;
      coef0_r  <= '0;
      coef1_r  <= '0;
      coef2_r  <= '0;
      coef3_r  <= '0;
      scale_r  <= 18'sd65536;
      offset_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rkcf_pkg::REG_KERNEL: ks_r     <= cfg_data[2:0];
        rkcf_pkg::REG_WIDTH:  width_r  <= cfg_data[11:0];
        rkcf_pkg::REG_COEF0:  coef0_r  <= cfg_data;
        rkcf_pkg::REG_COEF1:  coef1_r  <= cfg_data;
        rkcf_pkg::REG_COEF2:  coef2_r  <= cfg_data;
        rkcf_pkg::REG_COEF3:  coef3_r  <= cfg_data[7:0];
        rkcf_pkg::REG_SCALE:  scale_r  <= signed'(cfg_data[17:0]);
        rkcf_pkg::REG_OFFSET: offset_r <= signed'(cfg_data[9:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        ctl.shift = 1'b1;
        ctl.clear = 1'b1;
        state_nxt = emit ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        ctl.mac_en = 1'b1;
        if (mac_last) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        ctl.scale_en = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD) begin
        if (last_r) begin
          col_r <= '0;
          row_r <= '0;
        end else if (cnext >= weff) begin
          col_r <= '0;
          if (row_r < 12'(rkcf_pkg::ROW_MAX)) begin
            row_r <= row_r + 12'd1;
          end
        end else begin
          col_r <= CW'(cnext);
        end
      end
      if (state_r == S_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request payload and result coordinates.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_tdata;
      last_r <= in_tlast;
    end
    if (state_r == S_LOAD) begin
      ocol_r <= 11'(col_r - CW'(half));
      orow_r <= row_r - 12'(half);
    end
    if (state_r == S_FIN && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {1'b0, orow_r, ocol_r, r_b, r_g, r_r, r_a};
    end
  end

  rkcf_lbuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_lbuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (above),
    .wr_en   (state_r == S_LOAD),
    .wr_addr (col_r),
    .wr_data ({above[LW-33:0], pix_in})
  );

  rkcf_core #(
    .MAX_KERNEL (MAX_KERNEL),
    .COEF_BITS  (COEF_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .k5        (k5),
    .pix       (pix_in),
    .above     (above),
    .coefs     ({coef3_r, coef2_r, coef1_r, coef0_r}),
    .recip     (scale_r),
    .offset    (offset_r),
    .mac_last  (mac_last),
    .res_alpha (r_a),
    .res_red   (r_r),
    .res_green (r_g),
    .res_blue  (r_b)
  );

endmodule

// File: rtl/rkcf_lbuf.sv
module rkcf_lbuf #(
  parameter int MAX_WIDTH  = rkcf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = rkcf_pkg::MAX_KERNEL_DEF
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]             rd_addr,
  output logic [(MAX_KERNEL-1)*rkcf_pkg::PIX_W-1:0] rd_data,
  input  logic                                     wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]             wr_addr,
  input  logic [(MAX_KERNEL-1)*rkcf_pkg::PIX_W-1:0] wr_data
);

  localparam int LW = (MAX_KERNEL-1)*rkcf_pkg::PIX_W;

  // One word per column: the pixels of the rows above, nearest in the low bits.
  logic [LW-1:0] mem [MAX_WIDTH];
  logic [LW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/rkcf_core.sv
module rkcf_core #(
  parameter int MAX_KERNEL = rkcf_pkg::MAX_KERNEL_DEF,
  parameter int COEF_BITS  = rkcf_pkg::COEF_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  rkcf_pkg::ctl_t                            ctl,
  input  logic                                      k5,
  input  logic [rkcf_pkg::PIX_W-1:0]                pix,
  input  logic [(MAX_KERNEL-1)*rkcf_pkg::PIX_W-1:0] above,
  input  logic [rkcf_pkg::COEF_VEC_W-1:0]           coefs,
  input  logic signed [rkcf_pkg::SCALE_W-1:0]       recip,
  input  logic signed [rkcf_pkg::OFFS_W-1:0]        offset,
  output logic                                      mac_last,
  output logic [7:0]                                res_alpha,
  output logic [7:0]                                res_red,
  output logic [7:0]                                res_green,
  output logic [7:0]                                res_blue
);

  localparam int IW = $clog2(MAX_KERNEL);
  localparam int CB = (COEF_BITS < 8) ? COEF_BITS : 8;
  localparam int PW = rkcf_pkg::PIX_W;
  localparam int AW = rkcf_pkg::ACC_W;
  localparam int TW = rkcf_pkg::PROD_W + 1;

  logic [PW-1:0] win_r [MAX_KERNEL][MAX_KERNEL];
  logic [IW-1:0] mx_r, my_r;
  logic [4:0]    idx_r;
  logic signed [AW-1:0] acc_r [3];
  logic signed [rkcf_pkg::PROD_W-1:0] prod_r [3];

  logic [IW-1:0] kmax, base, half, ctr;
  logic [PW-1:0] tap;
  logic [7:0]    cbyte;
  logic signed [8:0] cval;
  logic [7:0]    res [3];

  always_comb begin
    kmax = k5 ? IW'(4) : IW'(2);
    base = k5 ? IW'(MAX_KERNEL-5) : IW'(MAX_KERNEL-3);
    half = k5 ? IW'(2) : IW'(1);
    ctr  = IW'(MAX_KERNEL-1) - half;
    tap  = win_r[base + my_r][base + mx_r];
    cbyte = coefs[idx_r*8 +: 8];
    cval  = 9'(signed'(cbyte[CB-1:0]));
    mac_last = (mx_r == kmax) && (my_r == kmax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int j = 0; j < MAX_KERNEL; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int j = 0; j < MAX_KERNEL-1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
      end
      win_r[MAX_KERNEL-1][MAX_KERNEL-1] <= pix;
      for (int j = 0; j < MAX_KERNEL-1; j++) begin
        win_r[MAX_KERNEL-2-j][MAX_KERNEL-1] <= above[j*PW +: PW];
      end
    end
  end

  // Tap walk: one window position per cycle, all three channels together.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mx_r  <= '0;
      my_r  <= '0;
      idx_r <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end else if (ctl.mac_en) begin
      idx_r <= idx_r + 5'd1;
      if (mx_r == kmax) begin
        mx_r <= '0;
        my_r <= my_r + IW'(1);
      end else begin
        mx_r <= mx_r + IW'(1);
      end
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + AW'($signed({1'b0, tap[(2-c)*8 +: 8]}) * cval);
      end
    end
    if (ctl.scale_en) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= acc_r[c] * recip;
      end
    end
  end

  // A negative total clamps to zero, and a quotient above 255 saturates to 255.
  always_comb begin
    logic signed [TW-1:0] t;
    logic [TW-17:0] q;
    for (int c = 0; c < 3; c++) begin
      t = TW'(prod_r[c]) + (TW'(offset) <<< 16);
      q = (TW-16)'(t >>> 16);
      if (t[TW-1]) begin
        res[c] = 8'd0;
      end else if (q > (TW-16)'(255)) begin
        res[c] = 8'hFF;
      end else begin
        res[c] = q[7:0];
      end
    end
  end

  assign res_red   = res[0];
  assign res_green = res[1];
  assign res_blue  = res[2];
  assign res_alpha = win_r[ctr][ctr][31:24];

endmodule
